// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, branch codes and item types for the rotation-to-quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int W      = 16;               // sample width
  localparam int FRAC   = W - 2;            // fraction bits
  localparam int AW     = W + 3;            // trace / radicand argument width
  localparam int DW     = W + 1;            // off-diagonal sum width
  localparam int NW     = 2 * W;            // square-root input width
  localparam int SQS    = NW / 2;           // square-root stages
  localparam int NUMW   = DW + FRAC;        // dividend width
  localparam int QB     = NUMW - FRAC / 2 - 1; // quotient bits
  localparam int TDI_W  = ((9 * W + 7) / 8) * 8;
  localparam int TDO_W  = ((4 * W + 7) / 8) * 8;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

  // Classified item handed from front to back.
  typedef struct packed {
    logic                     bad;
    logic [1:0]               sel;
    logic [NW-1:0]            rad;
    logic [3:0][DW-1:0]       d;   // numerators for x, y, z, w slots
  } item_t;

endpackage

// ===== design/rotation_matrix_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shepperd conversion of a Q2.14 rotation matrix into a Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Pipeline: front register, queue, 16 square-root stages, prep stage,
//   23 divide stages, output register.
// Throughput: one word per cycle while the output is not stalled; the square root
//   and the four dividers are fully pipelined, each stage settling one result bit.
// Reset: synchronous; clears all valid flags and queue pointers, data holds.
module rotation_matrix_to_quaternion_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  input  logic [rmq_pkg::TDI_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // quat_x, quat_y, quat_z, quat_w from bit 0 up
  output logic [rmq_pkg::TDO_W-1:0]   m_tdata,
  // bad_matrix
  output logic                        m_tuser
);
  import rmq_pkg::*;

  logic [8:0][W-1:0] m;
  logic [3:0][W-1:0] quat;
  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  // Unpack the nine matrix entries, lowest first.
  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = s_tdata[i*W +: W];
  end

  // Classify: trace, branch, radicand and numerators.
  rmq_front u_front (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready), .m (m),
    .out_valid (f_valid), .out_ready (f_ready), .out_item (f_item)
  );

  // Decouple the classifier from the arithmetic pipeline.
  rmq_queue u_queue (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready), .in_item (f_item),
    .out_valid (q_valid), .out_ready (q_ready), .out_item (q_item)
  );

  // Square root, divide, saturate; the whole pipe holds when the output stalls.
  rmq_back u_back (
    .clk, .rst,
    .in_valid (q_valid), .in_ready (q_ready), .in_item (q_item),
    .out_valid (m_tvalid), .out_ready (m_tready),
    .out_quat (quat), .out_bad (m_tuser)
  );

  assign m_tdata = TDO_W'(quat);

endmodule

// ===== design/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Trace, branch choice, radicand and off-diagonal terms; one register stage.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [8:0][rmq_pkg::W-1:0]    m,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rmq_pkg::item_t                out_item
);
  import rmq_pkg::*;

  logic signed [AW-1:0] e [9];
  logic signed [AW-1:0] tr, arg;
  logic                 fv;
  item_t                item_next, item;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = AW'($signed(m[i]));
    end
    tr = e[0] + e[4] + e[8];
    item_next = '0;
    priority if (tr >= 0) begin
      item_next.sel = SEL_W;
      arg = tr + AW'(1 <<< FRAC);
    end else if (e[0] >= e[4] && e[0] >= e[8]) begin
      item_next.sel = SEL_X;
      arg = e[0] - e[4] - e[8] + AW'(1 <<< FRAC);
    end else if (e[4] >= e[8]) begin
      item_next.sel = SEL_Y;
      arg = e[4] - e[8] - e[0] + AW'(1 <<< FRAC);
    end else begin
      item_next.sel = SEL_Z;
      arg = e[8] - e[0] - e[4] + AW'(1 <<< FRAC);
    end
    item_next.bad = (arg <= 0);
    item_next.rad = item_next.bad ? '0 : (NW'(arg[W:0]) << FRAC);
    unique case (item_next.sel)
      SEL_W: begin
        item_next.d[0] = DW'(e[7] - e[5]);
        item_next.d[1] = DW'(e[2] - e[6]);
        item_next.d[2] = DW'(e[3] - e[1]);
        item_next.d[3] = '0;
      end
      SEL_X: begin
        item_next.d[0] = '0;
        item_next.d[1] = DW'(e[1] + e[3]);
        item_next.d[2] = DW'(e[6] + e[2]);
        item_next.d[3] = DW'(e[7] - e[5]);
      end
      SEL_Y: begin
        item_next.d[0] = DW'(e[1] + e[3]);
        item_next.d[1] = '0;
        item_next.d[2] = DW'(e[5] + e[7]);
        item_next.d[3] = DW'(e[2] - e[6]);
      end
      default: begin
        item_next.d[0] = DW'(e[6] + e[2]);
        item_next.d[1] = DW'(e[5] + e[7]);
        item_next.d[2] = '0;
        item_next.d[3] = DW'(e[3] - e[1]);
      end
    endcase
  end

  assign in_ready  = !fv || out_ready;
  assign out_valid = fv;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== design/rmq_queue.sv =====
// ----------------------------------------------------------------------------
// rmq_queue
// Short first-in first-out queue decoupling front and back.
// ----------------------------------------------------------------------------
module rmq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmq_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output rmq_pkg::item_t out_item
);
  import rmq_pkg::*;

  item_t        mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;
  logic           push, pop;

  assign in_ready  = (count != (QAW+1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

endmodule

// ===== design/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, four pipelined dividers, saturation and output word.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rmq_pkg::item_t             in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0][rmq_pkg::W-1:0] out_quat,
  output logic                       out_bad
);
  import rmq_pkg::*;

  typedef struct packed {
    logic               bad;
    logic [1:0]         sel;
    logic [3:0][DW-1:0] d;
    logic [NW-1:0]      rad;
    logic [W-1:0]       root;
    logic [W+1:0]       rem;
  } sq_t;

  typedef struct packed {
    logic               bad;
    logic [1:0]         sel;
    logic [W-1:0]       half;
    logic [W:0]         den;
    logic [3:0]         neg;
    logic [3:0][W:0]    rem;
    logic [3:0][QB-1:0] quo;
    logic [3:0][QB-1:0] low;
  } dv_t;

  function automatic sq_t sq_step(sq_t a);
    sq_t          r;
    logic [W+3:0] t, trial;
    r = a;
    t = {a.rem, a.rad[NW-1:NW-2]};
    trial = (W+4)'({a.root, 2'b01});
    r.rad = a.rad << 2;
    if (t >= trial) begin
      r.rem  = (W+2)'(t - trial);
      r.root = {a.root[W-2:0], 1'b1};
    end else begin
      r.rem  = t[W+1:0];
      r.root = {a.root[W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t prep(sq_t a);
    dv_t             r;
    logic [W:0]      h;
    logic [DW-1:0]   mag;
    logic [NUMW-1:0] num;
    r.bad = a.bad;
    r.sel = a.sel;
    h = ({1'b0, a.root} + 1'b1) >> 1;
    r.half = (h > (W+1)'((1 << (W-1)) - 1)) ? W'((1 << (W-1)) - 1) : h[W-1:0];
    r.den = {a.root, 1'b0};
    for (int k = 0; k < 4; k++) begin
      r.neg[k] = a.d[k][DW-1];
      mag = r.neg[k] ? (~a.d[k] + 1'b1) : a.d[k];
      num = {mag, FRAC'(0)} + NUMW'(a.root);
      r.rem[k] = (W+1)'(num[NUMW-1:QB]);
      r.low[k] = num[QB-1:0];
      r.quo[k] = '0;
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t a);
    dv_t        r;
    logic [W+1:0] t;
    logic       ge;
    r = a;
    for (int k = 0; k < 4; k++) begin
      t  = {a.rem[k], a.low[k][QB-1]};
      ge = (t >= {1'b0, a.den});
      r.rem[k] = ge ? (W+1)'(t - {1'b0, a.den}) : t[W:0];
      r.quo[k] = {a.quo[k][QB-2:0], ge};
      r.low[k] = a.low[k] << 1;
    end
    return r;
  endfunction

  sq_t  sq_in;
  sq_t  sq  [SQS];
  logic sqv [SQS];
  dv_t  pr;
  logic prv;
  dv_t  dv  [QB];
  logic dvv [QB];
  logic ov, en;
  logic [3:0][W-1:0] quat_next;

  assign en       = !ov || out_ready;
  assign in_ready = en;

  always_comb begin
    sq_in      = '0;
    sq_in.bad  = in_item.bad;
    sq_in.sel  = in_item.sel;
    sq_in.d    = in_item.d;
    sq_in.rad  = in_item.rad;
  end

  // Saturate each quotient, place the half root in the chosen slot; zero all on a bad matrix.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [QB-1:0] q;
      q = dv[QB-1].quo[k];
      if (dv[QB-1].neg[k]) begin
        quat_next[k] = (q > QB'(1 << (W-1))) ? W'(1 << (W-1)) : W'(~q + 1'b1);
      end else begin
        quat_next[k] = (q > QB'((1 << (W-1)) - 1)) ? W'((1 << (W-1)) - 1) : q[W-1:0];
      end
      if (2'(k) == dv[QB-1].sel) quat_next[k] = dv[QB-1].half;
      if (dv[QB-1].bad)          quat_next[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQS; i++) sqv[i] <= 1'b0;
      for (int i = 0; i < QB; i++)  dvv[i] <= 1'b0;
      prv <= 1'b0;
      ov  <= 1'b0;
    end else if (en) begin
      sqv[0] <= in_valid;
      for (int i = 1; i < SQS; i++) sqv[i] <= sqv[i-1];
      prv    <= sqv[SQS-1];
      dvv[0] <= prv;
      for (int i = 1; i < QB; i++) dvv[i] <= dvv[i-1];
      ov     <= dvv[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= sq_step(sq_in);
      for (int i = 1; i < SQS; i++) sq[i] <= sq_step(sq[i-1]);
      pr    <= prep(sq[SQS-1]);
      dv[0] <= dv_step(pr);
      for (int i = 1; i < QB; i++) dv[i] <= dv_step(dv[i-1]);
      out_quat <= quat_next;
      out_bad  <= dv[QB-1].bad;
    end
  end

  assign out_valid = ov;

endmodule

// ===== design/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the conversion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rmq_pkg::TDO_W-1:0] m_tdata,
  input logic                      m_tuser
);
  import rmq_pkg::*;

  // A stalled word holds.
  `ASSERT_SAME(a_hold, rst, $past(m_tvalid && !m_tready) && !$past(rst), m_tvalid && $stable(m_tdata))
  // A bad matrix yields a zero quaternion.
  `ASSERT_SAME(a_bad_zero, rst, m_tvalid && m_tuser, m_tdata == '0)
  // Nothing leaves just after reset.
  `ASSERT_NEXT(a_rst_quiet, rst, !m_tvalid)

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
